[rtl/chm_pkg.sv]
// Shared constants, types and codes of the chained hash map.
package chm_pkg;

  localparam int MAX_BUCKETS = 256;
  localparam int POOL_NODES  = 768;
  localparam int VALUE_WIDTH = 64;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 64;
  localparam int BC_W        = 9;
  localparam int TOTAL_SLOTS = MAX_BUCKETS + POOL_NODES;
  localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
  localparam int HEAD_W      = $clog2(MAX_BUCKETS);
  localparam int POOL_W      = $clog2(POOL_NODES + 1);
  localparam int CNT_W       = $clog2(TOTAL_SLOTS + 1);
  localparam int DIVC_W      = $clog2(KEY_W);
  // floor(x / 5) as (x * RECIP5) >> RECIP5_SH, exact for x up to 4 * 256.
  localparam int RECIP5      = 3277;
  localparam int RECIP5_SH   = 14;

  localparam logic [1:0] ST_STORED   = 2'd0;
  localparam logic [1:0] ST_FOUND    = 2'd1;
  localparam logic [1:0] ST_ABSENT   = 2'd2;
  localparam logic [1:0] ST_POOLFULL = 2'd3;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [VALUE_WIDTH-1:0] value;
    logic                   has_link;
    logic [SLOT_W-1:0]      link;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       div_last;
    logic       slot_from_link;
    logic       write_fill;
    logic       write_overwrite;
    logic       write_link;
    logic       write_node;
    logic       result_load;
    logic [1:0] result_status;
  } cmd_t;

  typedef struct packed {
    logic op_get;
    logic head_empty;
    logic key_match;
    logic has_link;
    logic pool_full;
  } sts_t;

endpackage

[rtl/chm_in_if.sv]
// Request channel: operation, key and value.
interface chm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [chm_pkg::KEY_W-1:0]   key;
  logic [chm_pkg::VALUE_W-1:0] value;
  modport source (output valid, operation, key, value, input ready);
  modport sink (input valid, operation, key, value, output ready);
endinterface

[rtl/chm_out_if.sv]
// Result channel: status, read value and load flag.
interface chm_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [chm_pkg::VALUE_W-1:0] read_value;
  logic                        load_high;
  modport source (output valid, status, read_value, load_high, input ready);
  modport sink (input valid, status, read_value, load_high, output ready);
endinterface

[rtl/chm_cfg_if.sv]
// Configuration write channel carrying the bucket count.
interface chm_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [chm_pkg::BC_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/chm_ram.sv]
// Generic single-port RAM with registered read.
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

[rtl/chm_ctrl.sv]
// Controller state machine sequencing modulo, chain walk and result hand-off.
module chm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  chm_pkg::sts_t sts_i,
  output chm_pkg::cmd_t cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_NODE = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [chm_pkg::DIVC_W-1:0]  cnt_q, cnt_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == chm_pkg::DIVC_W'(chm_pkg::KEY_W - 1)) begin
          cmd_o.div_last = 1'b1;
          state_d        = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts_i.head_empty) begin
          cmd_o.result_load = 1'b1;
          state_d           = S_DONE;
          if (sts_i.op_get) begin
            cmd_o.result_status = chm_pkg::ST_ABSENT;
          end else begin
            cmd_o.write_fill    = 1'b1;
            cmd_o.result_status = chm_pkg::ST_STORED;
          end
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.key_match) begin
          cmd_o.result_load = 1'b1;
          state_d           = S_DONE;
          if (sts_i.op_get) begin
            cmd_o.result_status = chm_pkg::ST_FOUND;
          end else begin
            cmd_o.write_overwrite = 1'b1;
            cmd_o.result_status   = chm_pkg::ST_STORED;
          end
        end else if (sts_i.has_link) begin
          cmd_o.slot_from_link = 1'b1;
          state_d              = S_LOOK;
        end else if (sts_i.op_get) begin
          cmd_o.result_load   = 1'b1;
          cmd_o.result_status = chm_pkg::ST_ABSENT;
          state_d             = S_DONE;
        end else if (sts_i.pool_full) begin
          cmd_o.result_load   = 1'b1;
          cmd_o.result_status = chm_pkg::ST_POOLFULL;
          state_d             = S_DONE;
        end else begin
          cmd_o.write_link = 1'b1;
          state_d          = S_NODE;
        end
      end
      S_NODE: begin
        cmd_o.write_node    = 1'b1;
        cmd_o.result_load   = 1'b1;
        cmd_o.result_status = chm_pkg::ST_STORED;
        state_d             = S_DONE;
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // The table lookup only evaluates read data from a read issued the cycle before.
  a_eval_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> $past(state_q) == S_LOOK)
    else $error("evaluation without a preceding read");

  // An accepted item always starts the modulo.
  a_accept_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DIV && cnt_q == '0)
    else $error("accepted item did not start the modulo");

  // A pool node is only written right after its parent's link was written.
  a_node_after_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NODE |-> $past(cmd_o.write_link))
    else $error("node fill without link update");
endmodule

[rtl/chm_dp.sv]
// Datapath: bucket modulo, slot table, pool and counters, result register.
module chm_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [chm_pkg::BC_W-1:0]         cfg_data_i,
  input  logic                             operation_i,
  input  logic [chm_pkg::KEY_W-1:0]        key_i,
  input  logic [chm_pkg::VALUE_W-1:0]      value_i,
  input  chm_pkg::cmd_t                    cmd_i,
  output chm_pkg::sts_t                    sts_o,
  output logic [1:0]                       status_o,
  output logic [chm_pkg::VALUE_W-1:0]      read_value_o,
  output logic                             load_high_o
);
  localparam int PROD_W = chm_pkg::BC_W + 2 + $clog2(chm_pkg::RECIP5 + 1);

  logic [chm_pkg::BC_W-1:0]        bc_q;
  logic [chm_pkg::BC_W-1:0]        eff;
  logic [PROD_W-1:0]               prod;
  logic [chm_pkg::CNT_W-1:0]       limit;
  logic                            op_q;
  logic [chm_pkg::KEY_W-1:0]       key_q, shk_q;
  logic [chm_pkg::VALUE_WIDTH-1:0] val_q;
  logic [chm_pkg::BC_W-1:0]        rem_q, rem_d;
  logic [chm_pkg::BC_W:0]          trial;
  logic [chm_pkg::SLOT_W-1:0]      slot_q, node_addr, ram_addr;
  logic [chm_pkg::MAX_BUCKETS-1:0] head_used_q;
  logic [chm_pkg::POOL_W-1:0]      pool_next_q;
  logic [chm_pkg::CNT_W-1:0]       count_q;
  logic                            ram_we;
  chm_pkg::entry_t                 wr_entry, rd_entry;
  logic [1:0]                      status_q;
  logic [chm_pkg::VALUE_W-1:0]     rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= chm_pkg::BC_W'(chm_pkg::MAX_BUCKETS);
    end else if (cfg_valid_i) begin
      bc_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (bc_q == '0) begin
      eff = chm_pkg::BC_W'(1);
    end else if (bc_q > chm_pkg::BC_W'(chm_pkg::MAX_BUCKETS)) begin
      eff = chm_pkg::BC_W'(chm_pkg::MAX_BUCKETS);
    end else begin
      eff = bc_q;
    end
  end

  // Four fifths of the bucket count through a reciprocal multiply.
  assign prod  = PROD_W'({eff, 2'b00}) * PROD_W'(chm_pkg::RECIP5);
  assign limit = chm_pkg::CNT_W'(prod >> chm_pkg::RECIP5_SH);

  // One restoring step of key modulo bucket count per cycle.
  assign trial = {rem_q, shk_q[chm_pkg::KEY_W-1]};
  assign rem_d = (trial >= {1'b0, eff}) ? chm_pkg::BC_W'(trial - {1'b0, eff})
                                        : chm_pkg::BC_W'(trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      key_q <= key_i;
      shk_q <= key_i;
      val_q <= value_i[chm_pkg::VALUE_WIDTH-1:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      shk_q <= shk_q << 1;
      rem_q <= rem_d;
    end
    if (cmd_i.div_step && cmd_i.div_last) begin
      slot_q <= chm_pkg::SLOT_W'(rem_d);
    end else if (cmd_i.slot_from_link) begin
      slot_q <= rd_entry.link;
    end
  end

  assign node_addr = chm_pkg::SLOT_W'(chm_pkg::MAX_BUCKETS) +
                     chm_pkg::SLOT_W'(pool_next_q);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = slot_q;
    wr_entry = rd_entry;
    if (cmd_i.write_fill) begin
      ram_we            = 1'b1;
      wr_entry.key      = key_q;
      wr_entry.value    = val_q;
      wr_entry.has_link = 1'b0;
      wr_entry.link     = '0;
    end else if (cmd_i.write_overwrite) begin
      ram_we         = 1'b1;
      wr_entry.value = val_q;
    end else if (cmd_i.write_link) begin
      ram_we            = 1'b1;
      wr_entry.has_link = 1'b1;
      wr_entry.link     = node_addr;
    end else if (cmd_i.write_node) begin
      ram_we            = 1'b1;
      ram_addr          = node_addr;
      wr_entry.key      = key_q;
      wr_entry.value    = val_q;
      wr_entry.has_link = 1'b0;
      wr_entry.link     = '0;
    end
  end

  chm_ram #(
    .WIDTH($bits(chm_pkg::entry_t)),
    .DEPTH(chm_pkg::TOTAL_SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(wr_entry),
    .rdata_o(rd_entry)
  );

  // Head slots carry a used bit each; a pool node is used once handed out,
  // and the walk only ever reaches handed-out nodes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_used_q <= '0;
      pool_next_q <= '0;
      count_q     <= '0;
    end else begin
      if (cmd_i.write_fill) begin
        head_used_q[slot_q[chm_pkg::HEAD_W-1:0]] <= 1'b1;
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.write_node) begin
        pool_next_q <= pool_next_q + 1'b1;
        count_q     <= count_q + 1'b1;
      end
    end
  end

  assign sts_o.op_get     = (op_q == chm_pkg::OP_GET);
  assign sts_o.head_empty = (slot_q < chm_pkg::SLOT_W'(chm_pkg::MAX_BUCKETS)) &&
                            !head_used_q[slot_q[chm_pkg::HEAD_W-1:0]];
  assign sts_o.key_match  = (rd_entry.key == key_q);
  assign sts_o.has_link   = rd_entry.has_link;
  assign sts_o.pool_full  = (pool_next_q >= chm_pkg::POOL_W'(chm_pkg::POOL_NODES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      status_q <= cmd_i.result_status;
      if (cmd_i.result_status == chm_pkg::ST_FOUND) begin
        rv_q <= chm_pkg::VALUE_W'(rd_entry.value);
      end else begin
        rv_q <= '0;
      end
    end
  end

  assign status_o     = status_q;
  assign read_value_o = rv_q;
  assign load_high_o  = (count_q > limit);

  // Every stored key sits in a used head slot or a handed-out pool node.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= chm_pkg::CNT_W'($countones(head_used_q)) + chm_pkg::CNT_W'(pool_next_q))
    else $error("stored count exceeds used slots");
endmodule

[rtl/chained_hash_map_core.sv]
// Top level of the chained hash map: controller, datapath and channel wiring.
//
//  channel  dir  payload                              handshake
//  in_i     in   operation, key, value                valid/ready
//  out_o    out  status, read_value, load_high        valid/ready
//  cfg_i    in   data = bucket count (9 bits)         valid/ready, always ready
//
// An item is accepted, goes through the bit-serial key modulo, then one lookup for an
// empty head slot or a read and an evaluation per occupied slot visited (slot
// memory read port), plus a write for a new pool node, then waits in the result
// register until taken. No clearing pass after reset: head slots have used bits
// and pool nodes follow a fill count.
// Input ready is high only while no item is in flight or waiting.
module chained_hash_map_core (
  input logic  clk_i,
  input logic  rst_ni,
  chm_in_if.sink    in_i,
  chm_out_if.source out_o,
  chm_cfg_if.sink   cfg_i
);
  chm_pkg::cmd_t cmd;
  chm_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  chm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .operation_i (in_i.operation),
    .key_i       (in_i.key),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .status_o    (out_o.status),
    .read_value_o(out_o.read_value),
    .load_high_o (out_o.load_high)
  );
endmodule

[verif/chained_hash_map_core_tb.sv]
// Self-checking testbench of the chained hash map core with its own table predictor.
module chained_hash_map_core_tb;

  typedef struct {
    logic                        op;
    logic [chm_pkg::KEY_W-1:0]   key;
    logic [chm_pkg::VALUE_W-1:0] value;
  } request_t;

  typedef struct {
    logic [1:0]                  status;
    logic [chm_pkg::VALUE_W-1:0] read_value;
    logic                        load_high;
  } answer_t;

  localparam int CYCLE_LIMIT = 6000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  chm_in_if  in_if ();
  chm_out_if out_if ();
  chm_cfg_if cfg_if ();

  chained_hash_map_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always #1 clk_i = ~clk_i;

  request_t   pending_reqs[$];
  answer_t    expected_answers[$];
  logic [chm_pkg::KEY_W-1:0] stored_keys[$];
  int         error_count = 0;
  int         poolfull_count = 0;
  int         cycle_count = 0;
  logic       quiet = 1'b0;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_cnt = 0;

  // Shadow copy of the table.
  logic                        tbl_used[chm_pkg::TOTAL_SLOTS];
  logic [chm_pkg::KEY_W-1:0]   tbl_key[chm_pkg::TOTAL_SLOTS];
  logic [chm_pkg::VALUE_W-1:0] tbl_value[chm_pkg::TOTAL_SLOTS];
  int                          tbl_link[chm_pkg::TOTAL_SLOTS];
  logic                        tbl_has_link[chm_pkg::TOTAL_SLOTS];
  int                          nodes_taken = 0;
  int                          entry_count = 0;
  logic [chm_pkg::BC_W-1:0]    bucket_setting = chm_pkg::BC_W'(chm_pkg::MAX_BUCKETS);

  initial begin
    for (int i = 0; i < chm_pkg::TOTAL_SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_has_link[i] = 1'b0;
    end
  end

  function automatic int buckets_in_use();
    if (bucket_setting == 0) return 1;
    if (bucket_setting > chm_pkg::MAX_BUCKETS) return chm_pkg::MAX_BUCKETS;
    return int'(bucket_setting);
  endfunction

  function automatic void put_entry(int s, logic [chm_pkg::KEY_W-1:0] k,
                                    logic [chm_pkg::VALUE_W-1:0] v);
    tbl_used[s] = 1'b1;
    tbl_key[s] = k;
    tbl_value[s] = v;
    tbl_has_link[s] = 1'b0;
    tbl_link[s] = 0;
    entry_count++;
  endfunction

  function automatic answer_t table_lookup_update(request_t r);
    answer_t a;
    int s;
    int node;
    int nb;
    nb = buckets_in_use();
    s = int'(r.key % nb);
    a.read_value = '0;
    a.status = (r.op == chm_pkg::OP_SET) ? chm_pkg::ST_POOLFULL : chm_pkg::ST_ABSENT;
    for (int steps = 0; steps < chm_pkg::TOTAL_SLOTS; steps++) begin
      if (r.op == chm_pkg::OP_SET) begin
        if (!tbl_used[s]) begin
          put_entry(s, r.key, r.value);
          a.status = chm_pkg::ST_STORED;
          break;
        end
        if (tbl_key[s] == r.key) begin
          tbl_value[s] = r.value;
          a.status = chm_pkg::ST_STORED;
          break;
        end
        if (!tbl_has_link[s]) begin
          if (nodes_taken >= chm_pkg::POOL_NODES) begin
            a.status = chm_pkg::ST_POOLFULL;
            break;
          end
          node = chm_pkg::MAX_BUCKETS + nodes_taken;
          nodes_taken++;
          tbl_link[s] = node;
          tbl_has_link[s] = 1'b1;
          put_entry(node, r.key, r.value);
          a.status = chm_pkg::ST_STORED;
          break;
        end
      end else begin
        if (!tbl_used[s]) break;
        if (tbl_key[s] == r.key) begin
          a.read_value = tbl_value[s];
          a.status = chm_pkg::ST_FOUND;
          break;
        end
        if (!tbl_has_link[s]) break;
      end
      s = tbl_link[s];
    end
    a.load_high = (entry_count > (nb * 4) / 5);
    return a;
  endfunction

  // Request driver; the prediction is made when an item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    request_t r;
    answer_t a;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.operation <= chm_pkg::OP_SET;
      in_if.key <= '0;
      in_if.value <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        r.op = in_if.operation;
        r.key = in_if.key;
        r.value = in_if.value;
        a = table_lookup_update(r);
        if (a.status == chm_pkg::ST_POOLFULL) poolfull_count++;
        expected_answers.push_back(a);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
          r = pending_reqs.pop_front();
          in_if.valid <= 1'b1;
          in_if.operation <= r.op;
          in_if.key <= r.key;
          in_if.value <= r.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    answer_t a;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_answers.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("Unexpected result: status %0d value %h load %0b",
                     out_if.status, out_if.read_value, out_if.load_high);
        end else begin
          a = expected_answers.pop_front();
          if (out_if.status !== a.status || out_if.read_value !== a.read_value ||
              out_if.load_high !== a.load_high) begin
            error_count++;
            if (error_count <= 10)
              $display("Mismatch: expected status %0d value %h load %0b, got %0d %h %0b",
                       a.status, a.read_value, a.load_high,
                       out_if.status, out_if.read_value, out_if.load_high);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 400;
        out_if.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet || ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_req(logic op, logic [chm_pkg::KEY_W-1:0] k,
                         logic [chm_pkg::VALUE_W-1:0] v);
    request_t r;
    r.op = op;
    r.key = k;
    r.value = v;
    pending_reqs.push_back(r);
    if (op == chm_pkg::OP_SET) stored_keys.push_back(k);
  endtask

  // Sampled on the falling edge so that the driver's updates have settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_reqs.size() > 0 || in_if.valid || expected_answers.size() > 0)
      @(negedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_buckets(logic [chm_pkg::BC_W-1:0] n);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= n;
    do @(posedge clk_i); while (!cfg_if.ready);
    bucket_setting = n;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [chm_pkg::KEY_W-1:0] pick_key();
    int c;
    c = $urandom_range(99);
    if (c < 40 && stored_keys.size() > 0)
      return stored_keys[$urandom_range(stored_keys.size() - 1)];
    if (c < 55) return chm_pkg::KEY_W'($urandom_range(999));
    return chm_pkg::KEY_W'($urandom);
  endfunction

  task automatic random_reqs(int n);
    for (int i = 0; i < n; i++)
      add_req(($urandom_range(99) < 55) ? chm_pkg::OP_SET : chm_pkg::OP_GET, pick_key(),
              {$urandom, $urandom});
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Key zero on an empty table must not match, then extremes and overwrite.
    add_req(chm_pkg::OP_GET, 32'd0, '1);
    add_req(chm_pkg::OP_SET, 32'd0, '0);
    add_req(chm_pkg::OP_GET, 32'd0, '0);
    add_req(chm_pkg::OP_SET, 32'hFFFF_FFFF, '1);
    add_req(chm_pkg::OP_GET, 32'hFFFF_FFFF, '0);
    add_req(chm_pkg::OP_SET, 32'hFFFF_FFFF, 64'h5555_5555_AAAA_AAAA);
    add_req(chm_pkg::OP_GET, 32'hFFFF_FFFF, '0);
    add_req(chm_pkg::OP_GET, 32'd256, '0);
    add_req(chm_pkg::OP_SET, 32'd256, 64'd1);
    add_req(chm_pkg::OP_SET, 32'd512, 64'h8000_0000_0000_0000);
    add_req(chm_pkg::OP_GET, 32'd512, '0);
    add_req(chm_pkg::OP_GET, 32'd768, '0);
    add_req(chm_pkg::OP_SET, 32'd256, 64'd2);
    add_req(chm_pkg::OP_GET, 32'd256, '0);
    add_req(chm_pkg::OP_GET, 32'd0, '0);
    wait_drained();

    // Small and out-of-range bucket counts; no rehash on reconfiguration.
    write_buckets(9'd1);
    random_reqs(15);
    wait_drained();
    write_buckets(9'd0);
    random_reqs(10);
    wait_drained();
    write_buckets(9'd511);
    random_reqs(15);
    wait_drained();

    write_buckets(9'd200);
    random_reqs(40);
    while (pending_reqs.size() > 20) @(posedge clk_i);
    @(posedge clk_i);
    hold_req <= 1'b1;
    random_reqs(40);
    wait_drained();

    // Grow one chain until the node pool runs out, without idling.
    write_buckets(9'd1);
    quiet <= 1'b1;
    for (int b = 0; b < 60 && poolfull_count < 10; b++) begin
      for (int i = 0; i < 20; i++)
        add_req(chm_pkg::OP_SET, chm_pkg::KEY_W'($urandom), {$urandom, $urandom});
      while (pending_reqs.size() > 0) @(posedge clk_i);
    end
    wait_drained();
    write_buckets(9'd256);
    random_reqs(25);
    wait_drained();
    quiet <= 1'b0;
    random_reqs(15);
    wait_drained();

    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
